FILE: rtl/rsh_flow_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// rsh_flow_classifier_core_defines.svh
// Assertion macros shared by the remote-shell classifier RTL.
// ----------------------------------------------------------------------------
`ifndef RSH_FLOW_CLASSIFIER_CORE_DEFINES_SVH
`define RSH_FLOW_CLASSIFIER_CORE_DEFINES_SVH

// Checked on every rising edge of clk, off while rst_n is low.
`define RSH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication form: antecedent in the same cycle.
`define RSH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/rsh_pkg.sv
// ----------------------------------------------------------------------------
// rsh_pkg
// Types and constants of the remote-shell flow classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rsh_pkg;

    localparam int BYTE_W    = 8;
    localparam int PORT_W    = 16;
    localparam int PKTNUM_W  = 8;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_DETECTED  = 2'd1,
        VERDICT_EXCLUDED  = 2'd2
    } verdict_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_PORT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDSTREAM_MIN = 2'd1;

    localparam logic [PORT_W-1:0]   SERVICE_PORT_RST  = 16'd514;
    localparam logic [PKTNUM_W-1:0] MIDSTREAM_MIN_RST = 8'd5;

    localparam logic [BYTE_W-1:0] ASCII_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] ASCII_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_PRT_LO  = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_PRT_HI  = 8'h7E;

    localparam logic [PKTNUM_W-1:0] PKT_NUM_FIRST  = 8'd1;
    localparam logic [PKTNUM_W-1:0] PKT_NUM_SECOND = 8'd2;

    // packet length limits, counting the last byte
    localparam int PKT1_LEN_MIN = 2;
    localparam int PKT1_LEN_MAX = 6;
    localparam int PKT2_LEN_MIN = 3;

    localparam logic [1:0] NUL_SAT = 2'd2;

    // per-packet flags, as seen before the current byte
    typedef struct packed {
        logic       digits_only;
        logic [1:0] nul_count;
        logic       unprintable_seen;
        logic       len1_ok_lo;   // length with last byte reaches packet 1 minimum
        logic       len1_ok_hi;   // length with last byte within packet 1 maximum
        logic       len2_ok;      // length with last byte reaches packet 2 minimum
    } pkt_flags_t;

    typedef struct packed {
        verdict_t verdict;
        logic     credentials_seen;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/rsh_pkt_track.sv
// ----------------------------------------------------------------------------
// rsh_pkt_track
// Per-packet byte count, digit, NUL and printable tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_pkt_track #(
    parameter int MAX_PAYLOAD = 2048
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [rsh_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                       last,
    output rsh_pkg::pkt_flags_t             flags
);
    import rsh_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             digits_only_reg, digits_only_next;
    logic [1:0]       nul_count_reg, nul_count_next;
    logic             unprint_reg, unprint_next;

    logic is_digit;
    logic is_print;

    assign is_digit = byte_in inside {[ASCII_ZERO:ASCII_NINE]};
    assign is_print = byte_in inside {[ASCII_PRT_LO:ASCII_PRT_HI]};

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        digits_only_next = digits_only_reg;
        nul_count_next   = nul_count_reg;
        unprint_next     = unprint_reg;
        if (step)
        begin
            if (last)
            begin
                byte_count_next  = '0;
                digits_only_next = 1'b1;
                nul_count_next   = '0;
                unprint_next     = 1'b0;
            end
            else
            begin
                if (!is_digit)
                    digits_only_next = 1'b0;
                if (byte_in == ASCII_NUL)
                begin
                    if (nul_count_reg < NUL_SAT)
                        nul_count_next = nul_count_reg + 2'd1;
                end
                else if (nul_count_reg < NUL_SAT && !is_print)
                begin
                    unprint_next = 1'b1;
                end
                if (byte_count_reg < CNT_MAX)
                    byte_count_next = byte_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            digits_only_reg <= 1'b1;
            nul_count_reg   <= '0;
            unprint_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            digits_only_reg <= digits_only_next;
            nul_count_reg   <= nul_count_next;
            unprint_reg     <= unprint_next;
        end
    end

    // length tests on the count of earlier bytes (length minus one)
    assign flags.digits_only      = digits_only_reg;
    assign flags.nul_count        = nul_count_reg;
    assign flags.unprintable_seen = unprint_reg;
    assign flags.len1_ok_lo = byte_count_reg >= CNT_W'(PKT1_LEN_MIN - 1);
    assign flags.len1_ok_hi = byte_count_reg <= CNT_W'(PKT1_LEN_MAX - 1);
    assign flags.len2_ok    = byte_count_reg >= CNT_W'(PKT2_LEN_MIN - 1);

endmodule

`default_nettype wire

FILE: rtl/rsh_classify.sv
// ----------------------------------------------------------------------------
// rsh_classify
// End-of-packet verdict from the last byte, ports and packet flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_classify (
    input  wire logic [rsh_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic [rsh_pkg::PKTNUM_W-1:0] packet_num,
    input  wire logic [rsh_pkg::PORT_W-1:0]   src_port,
    input  wire logic [rsh_pkg::PORT_W-1:0]   dst_port,
    input  wire logic [rsh_pkg::PORT_W-1:0]   svc_port,
    input  wire logic [rsh_pkg::PKTNUM_W-1:0] min_packets,
    input  rsh_pkg::pkt_flags_t               flags,
    output rsh_pkg::result_t                  result
);
    import rsh_pkg::*;

    logic port_hit;
    logic pkt1_ok;
    logic pkt2_ok;

    assign port_hit = (dst_port == svc_port || src_port == svc_port)
                      && byte_in == ASCII_LF;

    assign pkt1_ok = flags.len1_ok_lo && flags.len1_ok_hi && flags.digits_only;

    // last byte is NUL, so two NULs means at least one earlier
    assign pkt2_ok = flags.len2_ok && byte_in == ASCII_NUL
                     && flags.nul_count != 2'd0 && !flags.unprintable_seen;

    always_comb
    begin
        result.verdict          = VERDICT_EXCLUDED;
        result.credentials_seen = 1'b0;
        if (port_hit)
        begin
            result.verdict = (packet_num > min_packets) ? VERDICT_DETECTED
                                                        : VERDICT_UNDECIDED;
        end
        else if (packet_num == PKT_NUM_FIRST)
        begin
            result.verdict = pkt1_ok ? VERDICT_UNDECIDED : VERDICT_EXCLUDED;
        end
        else if (packet_num == PKT_NUM_SECOND)
        begin
            if (pkt2_ok)
            begin
                result.verdict          = VERDICT_DETECTED;
                result.credentials_seen = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rsh_flow_classifier_core.sv
// Throughput: one payload byte per cycle, but an end-of-packet byte stalls
// while a verdict waits in the result register under out_stall; bytes that
// end no packet give no result and are absorbed even while a verdict waits.
// The per-packet tracking state updates as each byte leaves the input register.
// Reset (rst_n, async, active low) clears the pipeline valids and packet state
// and loads service_port = 514, midstream_min_packets = 5.
// ----------------------------------------------------------------------------
// rsh_flow_classifier_core
// Remote-shell flow classifier over a TCP payload byte stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rsh_flow_classifier_core_defines.svh"

module rsh_flow_classifier_core #(
    parameter int MAX_PAYLOAD = 2048
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rsh_pkg::BYTE_W-1:0]    payload_byte,
    input  wire logic                          end_of_packet,
    input  wire logic [rsh_pkg::PKTNUM_W-1:0]  packet_number,
    input  wire logic [rsh_pkg::PORT_W-1:0]    source_port,
    input  wire logic [rsh_pkg::PORT_W-1:0]    dest_port,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [rsh_pkg::VERDICT_W-1:0]      verdict,
    output logic                               credentials_seen,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rsh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rsh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rsh_pkg::*;

    // configuration
    logic [PORT_W-1:0]   svc_port_reg;
    logic [PKTNUM_W-1:0] min_pkts_reg;

    // input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                eop_reg;
    logic [PKTNUM_W-1:0] pnum_reg;
    logic [PORT_W-1:0]   sport_reg;
    logic [PORT_W-1:0]   dport_reg;

    // result register
    logic                out_valid_reg;
    result_t             result_reg;

    logic       in_take;
    logic       out_free;
    logic       advance;
    pkt_flags_t flags;
    result_t    result_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svc_port_reg <= SERVICE_PORT_RST;
            min_pkts_reg <= MIDSTREAM_MIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SERVICE_PORT:  svc_port_reg <= cfg_data[PORT_W-1:0];
                CFG_MIDSTREAM_MIN: min_pkts_reg <= cfg_data[PKTNUM_W-1:0];
                default: ;
            endcase
        end
    end

    // non-final bytes never need the result register
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!eop_reg || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg  <= payload_byte;
            eop_reg   <= end_of_packet;
            pnum_reg  <= packet_number;
            sport_reg <= source_port;
            dport_reg <= dest_port;
        end
    end

    rsh_pkt_track #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (byte_reg),
        .last    (eop_reg),
        .flags   (flags)
    );

    rsh_classify u_classify (
        .byte_in     (byte_reg),
        .packet_num  (pnum_reg),
        .src_port    (sport_reg),
        .dst_port    (dport_reg),
        .svc_port    (svc_port_reg),
        .min_packets (min_pkts_reg),
        .flags       (flags),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && eop_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && eop_reg)
            result_reg <= result_next;
    end

    assign out_valid        = out_valid_reg;
    assign verdict          = result_reg.verdict;
    assign credentials_seen = result_reg.credentials_seen;

    `RSH_ASSERT_IMPL(a_creds_only_detected, out_valid_reg && result_reg.credentials_seen,
        result_reg.verdict == VERDICT_DETECTED, "credentials without detection")
    `RSH_ASSERT_IMPL(a_verdict_code, out_valid_reg,
        result_reg.verdict != 2'd3, "verdict code out of range")
    `RSH_ASSERT(a_result_from_eop, $rose(out_valid_reg) |-> $past(in_valid_reg && eop_reg),
        "result without an end-of-packet request")
    `RSH_ASSERT_IMPL(a_stall_only_on_eop, in_stall,
        in_valid_reg && eop_reg && out_valid_reg, "input stalled without cause")

endmodule

`default_nettype wire
